/* src/i2ctrm_pkg.sv */
// ----------------------------------------------------------------------------
// i2ctrm_pkg
// Shared types and constants for the i2c target register map.
// ----------------------------------------------------------------------------
package i2ctrm_pkg;

  localparam int MAP_SIZE = 64;
  localparam int ADDR_W   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;

  localparam logic [7:0] MAP_SIZE_B  = 8'(MAP_SIZE);
  localparam logic [8:0] MAP_SIZE_W  = 9'(MAP_SIZE);
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  typedef enum logic [3:0] {
    OP_ADDR  = 4'd0,
    OP_RX    = 4'd1,
    OP_TX    = 4'd2,
    OP_NACK  = 4'd3,
    OP_STOP  = 4'd4,
    OP_HWR8  = 4'd5,
    OP_HWR16 = 4'd6,
    OP_HRD8  = 4'd7,
    OP_HRD16 = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PH1,
    ST_PH2,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  bus_byte;
    logic [7:0]  host_index;
    logic [15:0] host_value;
  } item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic [15:0] host_read_data;
    logic [31:0] transaction_total;
  } result_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

/* src/i2ctrm_store.sv */
// ----------------------------------------------------------------------------
// i2ctrm_store
// Byte-wide single-port register store with registered read data, with
// per-entry valid bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module i2ctrm_store
  import i2ctrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]          mem [MAP_SIZE];
  logic [MAP_SIZE-1:0] valid_r;
  logic [7:0]          mem_rd_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.en && req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.en && !req.we) begin
      mem_rd_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else if (req.en) begin
      if (req.we) begin
        valid_r[req.addr] <= 1'b1;
      end else begin
        rd_vld_r <= valid_r[req.addr];
      end
    end
  end

  // entries never written since reset read as zero
  assign rdata = rd_vld_r ? mem_rd_r : 8'h00;

endmodule

/* src/i2ctrm_ctrl.sv */
// ----------------------------------------------------------------------------
// i2ctrm_ctrl
// Event sequencer: pointer, pointer-loaded flag, transaction counter, store
// access sequencing and the result register.
// ----------------------------------------------------------------------------
module i2ctrm_ctrl
  import i2ctrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res,
  output mem_req_t   mem_req,
  input  logic [7:0] mem_rdata
);

  state_t      state_r, state_nxt;
  logic        enable_r;
  logic [7:0]  ptr_r, ptr_nxt;
  logic        loaded_r, loaded_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic [3:0]  op_r;
  logic [7:0]  idx_r;
  logic [15:0] hval_r;
  logic        act_r, act_nxt;
  logic [7:0]  hi_r;

  logic [7:0]  res_tx_r, res_tx;
  logic [15:0] res_rd_r, res_rd;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;

  logic        accept;
  logic        slot_free;
  logic        load_out;
  logic [8:0]  idx_in_inc;
  logic [8:0]  idx_r_inc;

  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign idx_in_inc = {1'b0, in_item.host_index} + 9'd1;
  assign idx_r_inc  = {1'b0, idx_r} + 9'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PH1;
      end
      ST_PH1: begin
        if (op_r == OP_HRD16 && act_r) state_nxt = ST_PH2;
        else if (slot_free)            state_nxt = ST_IDLE;
        else                           state_nxt = ST_HOLD;
      end
      ST_PH2: begin
        state_nxt = slot_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready   = 1'b0;
    mem_req    = '0;
    ptr_nxt    = ptr_r;
    loaded_nxt = loaded_r;
    cnt_nxt    = cnt_r;
    act_nxt    = 1'b0;
    res_tx     = res_tx_r;
    res_rd     = res_rd_r;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_item.op)
            OP_ADDR: begin
              if (enable_r) loaded_nxt = 1'b0;
            end
            OP_RX: begin
              if (enable_r) begin
                if (!loaded_r) begin
                  ptr_nxt    = in_item.bus_byte;
                  loaded_nxt = 1'b1;
                end else if (ptr_r < MAP_SIZE_B) begin
                  mem_req.en    = 1'b1;
                  mem_req.we    = 1'b1;
                  mem_req.addr  = ptr_r[ADDR_W-1:0];
                  mem_req.wdata = in_item.bus_byte;
                  ptr_nxt       = ptr_r + 8'd1;
                end
              end
            end
            OP_TX: begin
              if (enable_r && ptr_r < MAP_SIZE_B) begin
                act_nxt      = 1'b1;
                mem_req.en   = 1'b1;
                mem_req.addr = ptr_r[ADDR_W-1:0];
                ptr_nxt      = ptr_r + 8'd1;
              end
            end
            OP_STOP: begin
              if (enable_r) begin
                loaded_nxt = 1'b0;
                cnt_nxt    = cnt_r + 32'd1;
              end
            end
            OP_HWR8: begin
              if (in_item.host_index < MAP_SIZE_B) begin
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = in_item.host_index[ADDR_W-1:0];
                mem_req.wdata = in_item.host_value[7:0] & BYTE_MASK;
              end
            end
            OP_HWR16: begin
              if (idx_in_inc < MAP_SIZE_W) begin
                act_nxt       = 1'b1;
                mem_req.en    = 1'b1;
                mem_req.we    = 1'b1;
                mem_req.addr  = in_item.host_index[ADDR_W-1:0];
                mem_req.wdata = in_item.host_value[15:8];
              end
            end
            OP_HRD8: begin
              if (in_item.host_index < MAP_SIZE_B) begin
                act_nxt      = 1'b1;
                mem_req.en   = 1'b1;
                mem_req.addr = in_item.host_index[ADDR_W-1:0];
              end
            end
            OP_HRD16: begin
              if (idx_in_inc < MAP_SIZE_W) begin
                act_nxt      = 1'b1;
                mem_req.en   = 1'b1;
                mem_req.addr = in_item.host_index[ADDR_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_PH1: begin
        res_tx = 8'h00;
        res_rd = 16'h0000;
        if (op_r == OP_TX && act_r) begin
          res_tx = mem_rdata;
        end
        if (op_r == OP_HRD8 && act_r) begin
          res_rd = {8'h00, mem_rdata};
        end
        if (op_r == OP_HWR16 && act_r) begin
          // low byte of a 16-bit pair goes to the next entry
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.addr  = idx_r_inc[ADDR_W-1:0];
          mem_req.wdata = hval_r[7:0];
        end
        if (op_r == OP_HRD16 && act_r) begin
          mem_req.en   = 1'b1;
          mem_req.addr = idx_r_inc[ADDR_W-1:0];
        end else begin
          load_out = slot_free;
        end
      end
      ST_PH2: begin
        res_tx   = 8'h00;
        res_rd   = {hi_r, mem_rdata};
        load_out = slot_free;
      end
      ST_HOLD: begin
        load_out = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      ptr_r       <= 8'h00;
      loaded_r    <= 1'b0;
      cnt_r       <= 32'h0;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      loaded_r    <= loaded_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) enable_r <= cfg_wdata;
      if (accept) act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_item.op;
      idx_r  <= in_item.host_index;
      hval_r <= in_item.host_value;
    end
    if (state_r == ST_PH1) begin
      hi_r <= mem_rdata;
    end
    res_tx_r <= res_tx;
    res_rd_r <= res_rd;
    if (load_out) begin
      out_res_r.tx_byte           <= res_tx;
      out_res_r.host_read_data    <= res_rd;
      out_res_r.transaction_total <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* src/i2c_target_register_map.sv */
// ----------------------------------------------------------------------------
// i2c_target_register_map
// Byte-wide register file behind an i2c target, with auto-increment pointer.
// ----------------------------------------------------------------------------
// Usage:
//   Each bus event or host access is one transaction on the in_ channel;
//   the op code travels in in_tuser. Every input transaction yields exactly
//   one result transaction on the out_ channel.
//   cfg_we/cfg_wdata set the enable bit; while it is low, bus events are
//   ignored and host accesses still work.
//   Each item is taken in the idle state and goes through an access phase
//   before the next is accepted; a 16-bit host read adds a second read phase,
//   since the byte-wide single-port store gives one byte per read. out_tvalid
//   is registered, set from the item's last phase once the output is free.
//   The result sits in an output register; if the receiver stalls, the
//   block still takes the next item and completes it into a holding stage,
//   accepting further items only once the output register frees up.
//   Reset (rst_n low, synchronous) clears pointer, flag, counter, enable and
//   the per-entry valid bits, so the whole store reads as zero at once.
// ----------------------------------------------------------------------------
module i2c_target_register_map
  import i2ctrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // bus_byte[7:0], host_index[15:8], host_value[31:16]
  input  logic [3:0]  in_tuser,   // op[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // tx_byte[7:0], host_read_data[23:8],
                                  // transaction_total[55:24]
);

  item_t    item;
  result_t  res;
  mem_req_t mem_req;
  logic [7:0] mem_rdata;

  assign item.op         = in_tuser;
  assign item.bus_byte   = in_tdata[7:0];
  assign item.host_index = in_tdata[15:8];
  assign item.host_value = in_tdata[31:16];

  i2ctrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  i2ctrm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign out_tdata = {res.transaction_total, res.host_read_data, res.tx_byte};

endmodule
